### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define MKSM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error(msg);

// expression is never true outside reset
`define MKSM_NEVER(lbl, clk, rstn, expr, msg) \
  `MKSM_ASSERT(lbl, clk, rstn, !(expr), msg)

`endif

### rtl/mksm_pkg.sv
// ----------------------------------------------------------------------------
// mksm_pkg
// Shared types and constants of the multi keyword stream matcher.
// ----------------------------------------------------------------------------
package mksm_pkg;

  localparam int NUM_KEYS_DEF    = 16;
  localparam int MAX_KEY_LEN_DEF = 40;

  localparam int OP_W       = 2;
  localparam int BYTE_W     = 8;
  localparam int SEL_W      = 4;
  localparam int POS_W      = 6;
  localparam int LEN_W      = 6;
  localparam int RES_W      = 5;
  localparam int KC_W       = 5;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_DATA     = 2'd0,
    OP_KEY_BYTE = 2'd1,
    OP_KEY_LEN  = 2'd2
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_RULE_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT   = 1'd1;

  // input tdata layout, lowest field last
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [POS_W-1:0]  pos;
    logic [SEL_W-1:0]  sel;
    logic [BYTE_W-1:0] data;
  } in_data_t;

  // keyword write command to the key store
  typedef struct packed {
    logic              byte_we;
    logic              len_we;
    logic [SEL_W-1:0]  sel;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] data;
  } key_wr_t;

  // window control broadcast to every cell
  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

endpackage

### rtl/mksm_cell.sv
// ----------------------------------------------------------------------------
// mksm_cell
// One window position: holds a buffer byte, passes it on, and compares it
// against the end-aligned keyword byte of every key at this position.
// ----------------------------------------------------------------------------
module mksm_cell #(
  parameter int NUM_KEYS = mksm_pkg::NUM_KEYS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mksm_pkg::win_ctl_t          ctl,
  input  logic [mksm_pkg::BYTE_W-1:0] din,
  input  logic                        din_vld,
  input  logic [NUM_KEYS-1:0]         a_we,
  input  logic [mksm_pkg::BYTE_W-1:0] a_byte,
  input  logic [NUM_KEYS-1:0]         b_we,
  input  logic [mksm_pkg::BYTE_W-1:0] b_byte,
  input  logic [NUM_KEYS-1:0]         key_en,
  output logic [mksm_pkg::BYTE_W-1:0] dout,
  output logic                        dout_vld,
  output logic [NUM_KEYS-1:0]         ok
);
  import mksm_pkg::*;

  logic [BYTE_W-1:0] win_r;
  logic              vld_r;
  logic [BYTE_W-1:0] pat_r [NUM_KEYS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.shift) begin
      vld_r <= din_vld;
    end else if (ctl.clear) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      win_r <= din;
    end
  end

  // byte write wins over a row realign of the same key
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (b_we[k]) begin
        pat_r[k] <= b_byte;
      end else if (a_we[k]) begin
        pat_r[k] <= a_byte;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      ok[k] = !key_en[k] || (vld_r && (pat_r[k] == win_r));
    end
  end

  assign dout     = win_r;
  assign dout_vld = vld_r;

endmodule

### rtl/mksm_key_store.sv
// ----------------------------------------------------------------------------
// mksm_key_store
// Keyword bytes and lengths. Keeps the raw keyword rows in a memory and
// drives the end-aligned copies held in the cells: a length write realigns
// the whole row in the following cycle, a byte write lands directly.
// ----------------------------------------------------------------------------
module mksm_key_store #(
  parameter int NUM_KEYS    = mksm_pkg::NUM_KEYS_DEF,
  parameter int MAX_KEY_LEN = mksm_pkg::MAX_KEY_LEN_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  mksm_pkg::key_wr_t                                 cmd,
  output logic [NUM_KEYS-1:0]                               len_ok,
  output logic [MAX_KEY_LEN-1:0][NUM_KEYS-1:0]              key_en,
  output logic [NUM_KEYS-1:0]                               a_we,
  output logic [MAX_KEY_LEN-1:0][mksm_pkg::BYTE_W-1:0]      a_row,
  output logic [NUM_KEYS-1:0]                               b_we,
  output logic [MAX_KEY_LEN-1:0]                            b_col,
  output logic [mksm_pkg::BYTE_W-1:0]                       b_byte
);
  import mksm_pkg::*;

  localparam int KEY_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int POS_IW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int ROW_W  = MAX_KEY_LEN * BYTE_W;
  localparam int SH_W   = LEN_W + 1;

  logic [ROW_W-1:0]  raw_mem [NUM_KEYS];
  logic [LEN_W-1:0]  len_r   [NUM_KEYS];
  logic [ROW_W-1:0]  row_r;
  logic [KEY_W-1:0]  rl_key_r;
  logic [LEN_W-1:0]  rl_len_r;
  logic              rl_vld_r;

  logic [KEY_W-1:0]  key_idx;
  logic [POS_IW-1:0] pos_idx;
  logic [ROW_W-1:0]  rev;
  logic [ROW_W-1:0]  aligned;
  logic [SH_W-1:0]   sh;
  logic [LEN_W-1:0]  cur_len;
  logic [LEN_W-1:0]  tgt;
  logic              b_hit;

  assign key_idx = KEY_W'(cmd.sel);
  assign pos_idx = POS_IW'(cmd.pos);

  always_ff @(posedge clk) begin
    if (cmd.byte_we) begin
      raw_mem[key_idx][pos_idx*BYTE_W +: BYTE_W] <= cmd.data;
    end
    if (cmd.len_we) begin
      len_r[key_idx] <= cmd.len;
      row_r          <= raw_mem[key_idx];
      rl_key_r       <= key_idx;
      rl_len_r       <= cmd.len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rl_vld_r <= 1'b0;
    end else begin
      rl_vld_r <= cmd.len_we;
    end
  end

  // cell q gets keyword byte len-1-q
  always_comb begin
    for (int m = 0; m < MAX_KEY_LEN; m++) begin
      rev[m*BYTE_W +: BYTE_W] = row_r[(MAX_KEY_LEN-1-m)*BYTE_W +: BYTE_W];
    end
    sh      = SH_W'(MAX_KEY_LEN) - {1'b0, rl_len_r};
    aligned = rev >> (sh * BYTE_W);
  end

  assign a_row = aligned;

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      a_we[k] = rl_vld_r && (rl_key_r == KEY_W'(k));
    end
  end

  assign cur_len = len_r[key_idx];
  assign b_hit   = cmd.byte_we && (cmd.pos < cur_len);
  assign tgt     = cur_len - cmd.pos - LEN_W'(1);
  assign b_byte  = cmd.data;

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      b_we[k] = b_hit && (key_idx == KEY_W'(k));
    end
    for (int q = 0; q < MAX_KEY_LEN; q++) begin
      b_col[q] = (tgt == LEN_W'(q));
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      len_ok[k] = (len_r[k] != '0) && ({1'b0, len_r[k]} <= SH_W'(MAX_KEY_LEN));
      for (int q = 0; q < MAX_KEY_LEN; q++) begin
        key_en[q][k] = (SH_W'(q) < {1'b0, len_r[k]});
      end
    end
  end

endmodule

### rtl/mksm_out_fifo.sv
// ----------------------------------------------------------------------------
// mksm_out_fifo
// Two-entry result queue between the match stage and the output channel.
// ----------------------------------------------------------------------------
module mksm_out_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [mksm_pkg::RES_W-1:0] push_data,
  input  logic                       pop_rdy,
  output logic                       out_vld,
  output logic [mksm_pkg::RES_W-1:0] out_data,
  output logic [1:0]                 cnt
);
  import mksm_pkg::*;

  logic [RES_W-1:0] q_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             pop;

  assign out_vld  = (cnt_r != 2'd0);
  assign pop      = out_vld && pop_rdy;
  assign out_data = q_r[rd_ptr_r];
  assign cnt      = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### rtl/multi_keyword_stream_matcher.sv
// ----------------------------------------------------------------------------
// multi_keyword_stream_matcher
// Scans byte streams for up to NUM_KEYS stored keywords.
//
// Input channel: one item per handshake. tuser carries the operation: a
// buffer byte, a keyword byte write or a keyword length write. tlast marks
// the final byte of a buffer. At that byte one result item is sent: the
// lowest matching keyword number below key_count plus one, or zero.
// Config channel: index 0 rule_enable, index 1 key_count; always ready.
//
// Throughput is one item per clock while in_tready is high, set by the
// window cell row that shifts one byte per cycle and compares all keys in
// parallel. out_tvalid rises once the last byte has passed the match stage
// register and the result queue count register. A length write realigns its
// keyword row from the key memory in the following cycle.
// Reset clears the scan window, found flags and registers; keyword bytes and
// lengths are undefined until written. A stalled receiver fills a two-entry
// result queue, after which in_tready drops until a result is taken.
// ----------------------------------------------------------------------------
module multi_keyword_stream_matcher #(
  parameter int NUM_KEYS    = mksm_pkg::NUM_KEYS_DEF,
  parameter int MAX_KEY_LEN = mksm_pkg::MAX_KEY_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: data_byte[7:0], key_select[11:8], byte_position[17:12],
  //           length_value[23:18]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mksm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: operation[1:0]
  input  logic [mksm_pkg::OP_W-1:0]        in_tuser,
  input  logic                             in_tlast,
  // out_tdata: match_result[4:0], zero fill above
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mksm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mksm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mksm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mksm_pkg::*;

  in_data_t          in_d;
  op_t               op;
  logic              acc;
  logic              data_acc;
  key_wr_t           kcmd;
  win_ctl_t          wctl;

  logic              rule_en_r;
  logic [KC_W-1:0]   key_count_r;
  logic              stg_vld_r;
  logic              stg_last_r;
  logic [NUM_KEYS-1:0] found_r;

  logic [NUM_KEYS-1:0]                      len_ok;
  logic [MAX_KEY_LEN-1:0][NUM_KEYS-1:0]     key_en;
  logic [NUM_KEYS-1:0]                      a_we;
  logic [MAX_KEY_LEN-1:0][BYTE_W-1:0]       a_row;
  logic [NUM_KEYS-1:0]                      b_we;
  logic [MAX_KEY_LEN-1:0]                   b_col;
  logic [BYTE_W-1:0]                        b_byte;

  logic [BYTE_W-1:0]   cell_byte [MAX_KEY_LEN];
  logic                cell_vld  [MAX_KEY_LEN];
  logic [NUM_KEYS-1:0] cell_ok   [MAX_KEY_LEN];

  logic [NUM_KEYS-1:0] hit;
  logic [NUM_KEYS-1:0] flags;
  logic [RES_W-1:0]    res;
  logic                push;
  logic [1:0]          oq_cnt;
  logic [RES_W-1:0]    oq_data;

  assign in_d     = in_tdata;
  assign op       = op_t'(in_tuser);
  assign acc      = in_tvalid && in_tready;
  assign data_acc = acc && (op == OP_DATA);

  assign kcmd.byte_we = acc && (op == OP_KEY_BYTE) && (int'(in_d.sel) < NUM_KEYS)
                        && (int'(in_d.pos) < MAX_KEY_LEN);
  assign kcmd.len_we  = acc && (op == OP_KEY_LEN) && (int'(in_d.sel) < NUM_KEYS);
  assign kcmd.sel     = in_d.sel;
  assign kcmd.pos     = in_d.pos;
  assign kcmd.len     = in_d.len;
  assign kcmd.data    = in_d.data;

  // ---- configuration ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_en_r   <= 1'b0;
      key_count_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RULE_ENABLE: rule_en_r   <= cfg_data[0];
        REG_KEY_COUNT:   key_count_r <= cfg_data[KC_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- key store ----
  mksm_key_store #(
    .NUM_KEYS    (NUM_KEYS),
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_keys (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (kcmd),
    .len_ok (len_ok),
    .key_en (key_en),
    .a_we   (a_we),
    .a_row  (a_row),
    .b_we   (b_we),
    .b_col  (b_col),
    .b_byte (b_byte)
  );

  // ---- window cell row ----
  assign wctl.shift = data_acc;
  assign wctl.clear = stg_vld_r && stg_last_r;

  for (genvar q = 0; q < MAX_KEY_LEN; q++) begin : g_cell
    logic [BYTE_W-1:0]   din;
    logic                din_vld;
    logic [NUM_KEYS-1:0] b_we_q;

    if (q == 0) begin : g_head
      assign din     = in_d.data;
      assign din_vld = 1'b1;
    end else begin : g_body
      assign din     = cell_byte[q-1];
      assign din_vld = cell_vld[q-1] && !wctl.clear;
    end

    assign b_we_q = b_we & {NUM_KEYS{b_col[q]}};

    mksm_cell #(
      .NUM_KEYS (NUM_KEYS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (wctl),
      .din      (din),
      .din_vld  (din_vld),
      .a_we     (a_we),
      .a_byte   (a_row[q]),
      .b_we     (b_we_q),
      .b_byte   (b_byte),
      .key_en   (key_en[q]),
      .dout     (cell_byte[q]),
      .dout_vld (cell_vld[q]),
      .ok       (cell_ok[q])
    );
  end

  // ---- match stage ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= data_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (data_acc) begin
      stg_last_r <= in_tlast;
    end
  end

  always_comb begin
    hit = len_ok;
    for (int q = 0; q < MAX_KEY_LEN; q++) begin
      hit = hit & cell_ok[q];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= '0;
    end else if (stg_vld_r && stg_last_r) begin
      found_r <= '0;
    end else if (stg_vld_r) begin
      found_r <= found_r | hit;
    end
  end

  always_comb begin
    flags = found_r | hit;
    res   = '0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (flags[k] && rule_en_r && (k < int'(key_count_r))) begin
        res = RES_W'(k + 1);
      end
    end
  end

  assign push = stg_vld_r && stg_last_r;

  // ---- result queue ----
  mksm_out_fifo u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .pop_rdy   (out_tready),
    .out_vld   (out_tvalid),
    .out_data  (oq_data),
    .cnt       (oq_cnt)
  );

  assign out_tdata = {{(OUT_TDATA_W - RES_W){1'b0}}, oq_data};

  // room for one more result after this cycle's push and pop
  assign in_tready = (oq_cnt == 2'd0) ||
                     ((oq_cnt == 2'd1) && (!push || out_tready)) ||
                     ((oq_cnt == 2'd2) && !push && out_tready);

endmodule

### rtl/mksm_checker.sv
// ----------------------------------------------------------------------------
// mksm_checker
// Port-level checks of the matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mksm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [mksm_pkg::OP_W-1:0]        in_tuser,
  input logic                             in_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [mksm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import mksm_pkg::*;

  logic last_acc;

  assign last_acc = in_tvalid && in_tready && in_tlast && (in_tuser == OP_DATA);

  `MKSM_ASSERT(a_out_hold, clk, rst_n,
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)),
    "stalled result changed or dropped")

  `MKSM_ASSERT(a_res_after_last, clk, rst_n,
    $rose(out_tvalid) |-> $past(last_acc, 2),
    "result without a last data byte two cycles earlier")

  `MKSM_ASSERT(a_stall_cause, clk, rst_n,
    !in_tready |-> out_tvalid,
    "input stalled while no result is waiting")

  `MKSM_NEVER(a_pad_zero, clk, rst_n,
    out_tvalid && (out_tdata[7:5] != 3'd0),
    "result padding bits not zero")

endmodule

bind multi_keyword_stream_matcher mksm_checker u_mksm_checker (.*);

### tb/sv/mksm_match_checker.sv
// ----------------------------------------------------------------------------
// mksm_match_checker
// Watches the input, config and result channels of the keyword matcher.
// Mirrors the keyword store, registers and scan window, works out the match
// result of every buffer when its last byte is taken, and compares each
// result item against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module mksm_match_checker #(
  parameter int NUM_KEYS    = mksm_pkg::NUM_KEYS_DEF,
  parameter int MAX_KEY_LEN = mksm_pkg::MAX_KEY_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [mksm_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [mksm_pkg::OP_W-1:0]        in_tuser,
  input  logic                             in_tlast,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [mksm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [mksm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mksm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             drain,
  output int                               mismatches,
  output int                               pending,
  output int                               results_seen,
  output int                               hits_seen
);
  import mksm_pkg::*;

  logic [BYTE_W-1:0]   window [MAX_KEY_LEN];
  int                  fill;
  logic [NUM_KEYS-1:0] hits;
  logic [BYTE_W-1:0]   key_bytes [NUM_KEYS][MAX_KEY_LEN];
  logic [LEN_W-1:0]    key_len [NUM_KEYS];
  logic                rule_on;
  logic [KC_W-1:0]     key_cnt;
  logic [RES_W-1:0]    match_q [$];
  logic [RES_W-1:0]    expected_match;
  logic                drained;

  initial begin
    mismatches   = 0;
    pending      = 0;
    results_seen = 0;
    hits_seen    = 0;
    drained      = 1'b0;
    foreach (key_len[k]) key_len[k] = '0;
    foreach (key_bytes[k, i]) key_bytes[k][i] = '0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic clear_scan();
    foreach (window[i]) window[i] = '0;
    fill = 0;
    hits = '0;
  endtask

  // keyword k ends at the newest byte, wholly inside the current buffer
  function automatic logic key_hit(input int k);
    int n;
    int i;
    n = int'(key_len[k]);
    if (n == 0 || n > MAX_KEY_LEN || fill < n) return 1'b0;
    for (i = 0; i < n; i++)
      if (key_bytes[k][i] != window[n-1-i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic scan_item(input logic [OP_W-1:0] op, input in_data_t d, input logic last);
    int               k;
    int               i;
    logic [RES_W-1:0] res;
    case (op)
      OP_KEY_BYTE: begin
        if (d.sel < NUM_KEYS && d.pos < MAX_KEY_LEN) key_bytes[d.sel][d.pos] = d.data;
      end
      OP_KEY_LEN: begin
        if (d.sel < NUM_KEYS) key_len[d.sel] = d.len;
      end
      OP_DATA: begin
        for (i = MAX_KEY_LEN - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = d.data;
        if (fill < MAX_KEY_LEN) fill++;
        for (k = 0; k < NUM_KEYS; k++)
          if (key_hit(k)) hits[k] = 1'b1;
        if (last) begin
          res = '0;
          // registers take effect at the last byte; count above NUM_KEYS saturates
          if (rule_on) begin
            for (k = NUM_KEYS - 1; k >= 0; k--)
              if (hits[k] && k < key_cnt) res = RES_W'(k + 1);
          end
          match_q.push_back(res);
          clear_scan();
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rule_on = 1'b0;
      key_cnt = '0;
      clear_scan();
      match_q.delete();
    end else begin
      // a result never belongs to an item taken at the same edge
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (match_q.size() == 0) begin
          report_mismatch($sformatf("result item 0x%02h arrived with none expected",
                                    out_tdata));
        end else begin
          expected_match = match_q.pop_front();
          if (expected_match != 0) hits_seen++;
          if (out_tdata !== {{(OUT_TDATA_W-RES_W){1'b0}}, expected_match})
            report_mismatch($sformatf("match_result got 0x%02h, expected %0d",
                                      out_tdata, expected_match));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RULE_ENABLE: rule_on = cfg_data[0];
          REG_KEY_COUNT:   key_cnt = cfg_data[KC_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) scan_item(in_tuser, in_data_t'(in_tdata), in_tlast);
      if (drain && !drained) begin
        drained = 1'b1;
        if (match_q.size() != 0)
          report_mismatch($sformatf("%0d expected results never arrived", match_q.size()));
      end
    end
    pending = match_q.size();
  end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the multi keyword stream matcher.
// Loads keywords, runs a short directed set of buffers around the corner
// cases, then random buffers that often carry stored keywords, under three
// idling mixes and a series of register settings. The checker beside the
// block predicts and compares every result item.
// ----------------------------------------------------------------------------
module testbench;
  import mksm_pkg::*;

  localparam int NUM_KEYS      = NUM_KEYS_DEF;
  localparam int MAX_KEY_LEN   = MAX_KEY_LEN_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET   = 1700;
  localparam int SECTION_ITEMS = 140;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 600000;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]        in_tuser   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   drain      = 1'b0;

  int mismatches;
  int pending;
  int results_seen;
  int hits_seen;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int items_sent     = 0;
  int cycle_count    = 0;

  // what the stimulus has loaded, so buffers can carry real keywords
  logic [BYTE_W-1:0] key_img [NUM_KEYS][MAX_KEY_LEN];
  bit                key_written [NUM_KEYS][MAX_KEY_LEN];
  int                key_len_img [NUM_KEYS];

  multi_keyword_stream_matcher #(
    .NUM_KEYS    (NUM_KEYS),
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  mksm_match_checker #(
    .NUM_KEYS    (NUM_KEYS),
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .drain        (drain),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen),
    .hits_seen    (hits_seen)
  );

  always #6 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results still due", cycle_count, pending);
    $display("Mismatches found");
    $finish;
  end

  // called and returns at a falling edge; leaves in_tvalid high
  task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                           input logic last, input int sel, input int pos, input int len);
    in_data_t d;
    d.data = data;
    d.sel  = SEL_W'(sel);
    d.pos  = POS_W'(pos);
    d.len  = LEN_W'(len);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= op;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (op != OP_UNUSED) items_sent++;
    if (op == OP_KEY_BYTE && sel < NUM_KEYS && pos < MAX_KEY_LEN) begin
      key_img[sel][pos]     = data;
      key_written[sel][pos] = 1'b1;
    end
    if (op == OP_KEY_LEN && sel < NUM_KEYS) key_len_img[sel] = len;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(9))
      0, 1:    return 8'h00;
      2, 3:    return 8'h5A;
      4:       return 8'hA5;
      5, 6:    return 8'hFF;
      default: return BYTE_W'($urandom_range(255));
    endcase
  endfunction

  function automatic int pick_key_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(4, 1);
    if (r < 85) return $urandom_range(12, 5);
    if (r < 92) return $urandom_range(MAX_KEY_LEN, 13);
    if (r < 96) return 0;
    return $urandom_range(63, MAX_KEY_LEN + 1);
  endfunction

  function automatic int pick_buf_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(8, 1);
    if (r < 90) return $urandom_range(30, 9);
    if (r < 97) return $urandom_range(60, 31);
    return $urandom_range(100, 61);
  endfunction

  task automatic data_byte(input logic [BYTE_W-1:0] b, input logic last);
    send_item(OP_DATA, b, last, $urandom_range(15), $urandom_range(63), $urandom_range(63));
  endtask

  task automatic write_key_byte(input int sel, input int pos, input logic [BYTE_W-1:0] b);
    send_item(OP_KEY_BYTE, b, 1'($urandom_range(1)), sel, pos, $urandom_range(63));
  endtask

  // a usable length only goes in once every byte it covers has been written
  task automatic write_key_len(input int sel, input int len);
    int p;
    if (len <= MAX_KEY_LEN) begin
      for (p = 0; p < len; p++)
        if (!key_written[sel][p]) write_key_byte(sel, p, pick_byte());
    end
    send_item(OP_KEY_LEN, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), sel,
              $urandom_range(63), len);
  endtask

  task automatic load_keyword(input int sel, input int len);
    int p;
    if (len <= MAX_KEY_LEN) begin
      for (p = 0; p < len; p++) write_key_byte(sel, p, pick_byte());
    end
    write_key_len(sel, len);
  endtask

  // embed_key < 0 picks a keyword at random, most of the time
  task automatic send_buffer(input int n, input bit close, input int embed_key);
    logic [BYTE_W-1:0] stream_bytes [128];
    int                i;
    int                k;
    int                off;
    for (i = 0; i < n; i++) stream_bytes[i] = pick_byte();
    k = embed_key;
    if (k < 0 && $urandom_range(99) < 70) k = $urandom_range(NUM_KEYS - 1);
    if (k >= 0 && key_len_img[k] >= 1 && key_len_img[k] <= MAX_KEY_LEN &&
        key_len_img[k] <= n) begin
      off = $urandom_range(n - key_len_img[k]);
      for (i = 0; i < key_len_img[k]; i++) stream_bytes[off + i] = key_img[k][i];
    end
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < 3) begin
        k = $urandom_range(NUM_KEYS - 1);
        if ($urandom_range(1)) write_key_byte(k, $urandom_range(MAX_KEY_LEN - 1), pick_byte());
        else write_key_len(k, pick_key_len());
      end
      data_byte(stream_bytes[i], close && i == n - 1);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(input int enable, input int count);
    write_reg(REG_RULE_ENABLE, enable);
    write_reg(REG_KEY_COUNT, count);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // hold the sender until every result is in, then let the pipeline drain
  task automatic settle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int s;
    int k;
    int r;
    int stop_at;
    foreach (key_written[i, j]) key_written[i][j] = 1'b0;
    foreach (key_len_img[i]) key_len_img[i] = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // every length is read on each data byte, so all start at zero
    for (k = 0; k < NUM_KEYS; k++) send_item(OP_KEY_LEN, '0, 1'b0, k, 0, 0);
    settle();
    configure(1, NUM_KEYS);

    // one-byte keyword at the top of the byte range
    write_key_byte(3, 0, 8'hFF);
    write_key_len(3, 1);
    data_byte(8'hFF, 1'b1);
    // all-zero keyword: the cleared window must not count as buffer bytes
    write_key_byte(1, 0, 8'h00);
    write_key_byte(1, 1, 8'h00);
    write_key_byte(1, 2, 8'h00);
    write_key_len(1, 3);
    data_byte(8'h00, 1'b0);
    data_byte(8'h00, 1'b1);
    data_byte(8'h00, 1'b0);
    data_byte(8'h00, 1'b0);
    data_byte(8'h00, 1'b1);
    // lengths above the maximum are kept but never match; tlast on a write is ignored
    send_item(OP_KEY_LEN, 8'hFF, 1'b1, 5, 63, 63);
    send_item(OP_KEY_LEN, 8'h00, 1'b1, 6, 39, MAX_KEY_LEN + 1);
    // out-of-range byte positions are dropped, the last valid position is kept
    send_item(OP_KEY_BYTE, 8'h00, 1'b1, 3, 63, 63);
    send_item(OP_KEY_BYTE, 8'h00, 1'b0, 3, MAX_KEY_LEN, 0);
    send_item(OP_KEY_BYTE, 8'hA5, 1'b0, 15, MAX_KEY_LEN - 1, MAX_KEY_LEN);
    // unused opcode, even with tlast, does nothing
    send_item(OP_UNUSED, 8'hFF, 1'b1, 15, 63, 63);
    data_byte(8'hFF, 1'b1);
    // keyword written mid-buffer applies from the next byte on
    data_byte(8'h5A, 1'b0);
    write_key_byte(2, 0, 8'h5A);
    write_key_len(2, 1);
    data_byte(8'h5A, 1'b1);

    s = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      if (s < 4) begin
        src_idle_pct   = 16;
        sink_stall_pct = 86;
      end else if (s < 8) begin
        src_idle_pct   = 86;
        sink_stall_pct = 16;
      end else begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
      case (s)
        0:       configure(1, NUM_KEYS);
        1:       configure(0, NUM_KEYS);
        2:       configure(1, 0);
        3:       configure(1, 20);
        4:       configure(1, 31);
        5:       configure(1, 1);
        default: configure(int'($urandom_range(99) < 85), $urandom_range(NUM_KEYS));
      endcase
      if (s == 0) begin
        // full-length keyword: exactly filling one buffer, inside a longer one, and a buffer one byte too short
        load_keyword(14, MAX_KEY_LEN);
        send_buffer(MAX_KEY_LEN, 1'b1, 14);
        send_buffer(MAX_KEY_LEN + 25, 1'b1, 14);
        send_buffer(MAX_KEY_LEN - 1, 1'b1, 14);
      end
      stop_at = items_sent + SECTION_ITEMS;
      while (items_sent < stop_at) begin
        r = $urandom_range(99);
        if (r < 6) begin
          load_keyword($urandom_range(NUM_KEYS - 1), pick_key_len());
        end else if (r < 9) begin
          write_key_byte($urandom_range(NUM_KEYS - 1), $urandom_range(63), pick_byte());
        end else if (r < 10) begin
          send_item(OP_UNUSED, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                    $urandom_range(15), $urandom_range(63), $urandom_range(63));
        end else begin
          send_buffer(pick_buf_len(), 1'b1, -1);
        end
      end
      // sometimes the next register write lands in the middle of a buffer
      if ($urandom_range(2) == 0) send_buffer(pick_buf_len(), 1'b0, -1);
      s++;
    end

    settle();
    drain <= 1'b1;
    repeat (2) @(negedge clk);
    $display("Sent %0d items in %0d register settings; checked %0d results, %0d naming a keyword",
             items_sent, s + 1, results_seen, hits_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
